[design/second_greater_element_assert.svh]
// Assertion macros shared by the checker of second_greater_element.
// Depends on nothing; expects clk and rst_n to exist where a macro is used.
`ifndef SECOND_GREATER_ELEMENT_ASSERT_SVH
`define SECOND_GREATER_ELEMENT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SGE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SGE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/sge_pkg.sv]
// Package for second_greater_element: widths, sequencer states, compare result type.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package sge_pkg;

  localparam int DATA_W      = 32;
  localparam int POS_W       = 6;
  localparam int DEF_MAX_LEN = 64;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_HERE_RD,
    ST_HERE_LAT,
    ST_SCAN,
    ST_EMIT
  } state_t;

  // Result of one compare step
  typedef struct packed {
    logic greater;  // candidate strictly above the reference value
    logic second;   // this is the second such candidate
  } cmp_res_t;

endpackage

[design/sge_mem.sv]
// Value store of second_greater_element: one write port, one registered read port.
// Depends on sge_pkg for the data width and the default depth.
`timescale 1ns / 1ps

module sge_mem #(
  parameter int DEPTH = sge_pkg::DEF_MAX_LEN,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [sge_pkg::DATA_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output logic [sge_pkg::DATA_W-1:0] rd_data
);

  logic [sge_pkg::DATA_W-1:0] mem [DEPTH];
  logic [sge_pkg::DATA_W-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[design/sge_cmp.sv]
// Shared compare unit: signed greater-than of a candidate against the reference
// value, plus detection of the second hit. Depends on sge_pkg.
`timescale 1ns / 1ps

module sge_cmp (
  input  logic [sge_pkg::DATA_W-1:0] cand,
  input  logic [sge_pkg::DATA_W-1:0] here,
  input  logic                       first_seen,
  output sge_pkg::cmp_res_t          res
);

  // Signed compare; equal values never count
  always_comb begin
    res.greater = $signed(cand) > $signed(here);
    res.second  = res.greater && first_seen;
  end

endmodule

[design/second_greater_element.sv]
// Top level of second_greater_element: load sequencer, scan sequencer, output register.
// Depends on sge_pkg, sge_mem and sge_cmp.
//
//  channel  | ports                                  | moves
//  ---------+----------------------------------------+-------------------------------
//  in       | in_valid/in_ready, in_sample_value,    | one value per transaction
//           | in_end_of_sequence                     |
//  out      | out_valid/out_ready, out_position,     | one result per stored position
//           | out_second_greater, out_found, ...     |
//
// Loading accepts one value per transaction; in_ready is high only while loading.
// Each result comes from a scan of the values stored after its position, in which
// one memory read port feeds one comparator, one word a cycle.
// A stalled result holds in the output registers; nothing else advances meanwhile.
// rst_n is synchronous, active low, and returns the block to an empty load state.
`timescale 1ns / 1ps

module second_greater_element #(
  parameter int MAX_LEN = sge_pkg::DEF_MAX_LEN
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [sge_pkg::DATA_W-1:0] in_sample_value,
  input  logic                              in_end_of_sequence,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic        [sge_pkg::POS_W-1:0]  out_position,
  output logic signed [sge_pkg::DATA_W-1:0] out_second_greater,
  output logic                              out_found,
  output logic                              out_overflowed,
  output logic                              out_final_result
);

  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int AW = $clog2(MAX_LEN);
  localparam logic [CW-1:0] CAP = CW'(MAX_LEN);

  sge_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic          pend_r, pend_nxt;
  logic          hit_r, hit_nxt;
  logic [sge_pkg::DATA_W-1:0] here_r, here_nxt;
  logic [sge_pkg::DATA_W-1:0] res_r, res_nxt;
  logic          found_r, found_nxt;

  logic                       mem_we;
  logic                       mem_re;
  logic [AW-1:0]              mem_ra;
  logic [sge_pkg::DATA_W-1:0] mem_rd;
  sge_pkg::cmp_res_t          cmp;
  logic                       is_final;

  sge_mem #(
    .DEPTH (MAX_LEN),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (cnt_r[AW-1:0]),
    .wr_data (in_sample_value),
    .rd_en   (mem_re),
    .rd_addr (mem_ra),
    .rd_data (mem_rd)
  );

  sge_cmp u_cmp (
    .cand       (mem_rd),
    .here       (here_r),
    .first_seen (hit_r),
    .res        (cmp)
  );

  assign is_final = (i_r + CW'(1)) == cnt_r;

  // State and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sge_pkg::ST_LOAD;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      i_r     <= '0;
      k_r     <= '0;
      pend_r  <= 1'b0;
      hit_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
      i_r     <= i_nxt;
      k_r     <= k_nxt;
      pend_r  <= pend_nxt;
      hit_r   <= hit_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    here_r  <= here_nxt;
    res_r   <= res_nxt;
    found_r <= found_nxt;
  end

  // Sequencer: next state, memory control, datapath updates
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    i_nxt     = i_r;
    k_nxt     = k_r;
    pend_nxt  = pend_r;
    hit_nxt   = hit_r;
    here_nxt  = here_r;
    res_nxt   = res_r;
    found_nxt = found_r;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_ra    = k_r[AW-1:0];

    unique case (state_r)
      sge_pkg::ST_LOAD: begin
        if (in_valid) begin
          if (cnt_r < CAP) begin
            mem_we  = 1'b1;
            cnt_nxt = cnt_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;  // full: drop the value
          end
          if (in_end_of_sequence) begin
            i_nxt     = '0;
            state_nxt = sge_pkg::ST_HERE_RD;
          end
        end
      end

      // read the reference value of this position
      sge_pkg::ST_HERE_RD: begin
        mem_re    = 1'b1;
        mem_ra    = i_r[AW-1:0];
        k_nxt     = i_r + CW'(1);
        hit_nxt   = 1'b0;
        res_nxt   = '0;
        found_nxt = 1'b0;
        state_nxt = sge_pkg::ST_HERE_LAT;
      end

      // latch reference, issue first candidate read
      sge_pkg::ST_HERE_LAT: begin
        here_nxt = mem_rd;
        if (k_r < cnt_r) begin
          mem_re   = 1'b1;
          k_nxt    = k_r + CW'(1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        state_nxt = sge_pkg::ST_SCAN;
      end

      // one candidate compared per cycle while the next is read
      sge_pkg::ST_SCAN: begin
        if (pend_r && cmp.second) begin
          res_nxt   = mem_rd;
          found_nxt = 1'b1;
          pend_nxt  = 1'b0;
          state_nxt = sge_pkg::ST_EMIT;
        end else begin
          if (pend_r && cmp.greater) begin
            hit_nxt = 1'b1;
          end
          if (!pend_r) begin
            state_nxt = sge_pkg::ST_EMIT;
          end else if (k_r < cnt_r) begin
            mem_re = 1'b1;
            k_nxt  = k_r + CW'(1);
          end else begin
            pend_nxt = 1'b0;
          end
        end
      end

      // result waits in the output registers
      sge_pkg::ST_EMIT: begin
        if (out_ready) begin
          if (is_final) begin
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
            state_nxt = sge_pkg::ST_LOAD;
          end else begin
            i_nxt     = i_r + CW'(1);
            state_nxt = sge_pkg::ST_HERE_RD;
          end
        end
      end

      default: begin
        state_nxt = sge_pkg::ST_LOAD;
      end
    endcase
  end

  // Ports
  assign in_ready           = (state_r == sge_pkg::ST_LOAD);
  assign out_valid          = (state_r == sge_pkg::ST_EMIT);
  assign out_position       = sge_pkg::POS_W'(i_r);
  assign out_second_greater = res_r;
  assign out_found          = found_r;
  assign out_overflowed     = ovf_r;
  assign out_final_result   = is_final;

endmodule

[design/sge_checker.sv]
// Port-level checker for second_greater_element, bound to the top level.
// Depends on sge_pkg and second_greater_element_assert.svh.
`timescale 1ns / 1ps
`include "second_greater_element_assert.svh"

module sge_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic        [sge_pkg::POS_W-1:0]  out_position,
  input logic signed [sge_pkg::DATA_W-1:0] out_second_greater,
  input logic                              out_found,
  input logic                              out_final_result
);

  logic out_acc;
  logic out_last;
  logic out_mid;
  logic out_stall;
  logic out_miss;
  logic loading;

  assign out_acc   = out_valid && out_ready;
  assign out_last  = out_acc && out_final_result;
  assign out_mid   = out_acc && !out_final_result;
  assign out_stall = out_valid && !out_ready;
  assign out_miss  = out_valid && !out_found;
  assign loading   = in_ready && !out_valid;

  // loading and emitting never overlap
  `SGE_ASSERT_NOW(a_no_overlap, in_ready, !out_valid, "in_ready while a result is shown")
  // last result of a burst returns the block to loading
  `SGE_ASSERT_NEXT(a_final_to_load, out_last, loading, "no reload after final result")
  // any other result is followed by a scan, not by loading
  `SGE_ASSERT_NEXT(a_mid_to_scan, out_mid, !in_ready && !out_valid, "burst ended early")
  // not-found results carry zero
  `SGE_ASSERT_NOW(a_zero_missing, out_miss, out_second_greater == 0, "nonzero value on miss")
  // stalled result holds its position
  `SGE_ASSERT_NEXT(a_stall_hold, out_stall, out_valid && $stable(out_position), "stall dropped")

endmodule

bind second_greater_element sge_checker u_sge_checker (.*);
